>>> sv/mmcrx_pkg.sv
// ----------------------------------------------------------------------------
// mmcrx_pkg
// Shared types and constants for the one-bit MMC data block receiver.
// ----------------------------------------------------------------------------
package mmcrx_pkg;

   localparam int unsigned BlockBytes = 512;  // 1 .. 4096

   localparam logic [12:0] BLOCK_BYTES   = 13'(BlockBytes);
   localparam logic [12:0] CRC_BITS      = 13'd16;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HUNT = 3'd1,
      PH_DATA = 3'd2,
      PH_CRC  = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_OK      = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef enum logic {
      CMD_ARM    = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] received_crc;
      logic [31:0] crc_error_total;
   } res_type;

endpackage

>>> sv/mmcrx_engine.sv
// ----------------------------------------------------------------------------
// mmcrx_engine
// Receive state: start-bit hunt, byte packing, CRC16 and status decision.
// ----------------------------------------------------------------------------
module mmcrx_engine
   import mmcrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        command,
   input  logic        line_bit,
   input  logic [15:0] start_timeout,
   output res_type     res
);

   phase_type   phase_ff, phase_in;
   logic [15:0] hunt_ff, hunt_in;
   logic [12:0] idx_ff, idx_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] card_ff, card_in;
   logic [31:0] err_ff, err_in;

   logic        crc_fb;
   logic [15:0] crc_next;
   logic [7:0]  byte_next;
   logic [12:0] idx_inc;

   assign crc_fb    = crc_ff[15] ^ line_bit;
   assign crc_next  = {crc_ff[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'd0);
   assign byte_next = {shift_ff[6:0], line_bit};
   assign idx_inc   = idx_ff + 13'd1;

   always_comb begin
      phase_in = phase_ff;
      hunt_in  = hunt_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      card_in  = card_ff;
      err_in   = err_ff;
      res      = '0;
      res.kind = KIND_BYTE;
      res.crc_error_total = err_ff;

      if (step) begin
         if (cmd_type'(command) == CMD_ARM) begin
            phase_in = PH_HUNT;
            hunt_in  = start_timeout;
            idx_in   = '0;
            shift_in = '0;
            cnt_in   = '0;
            crc_in   = '0;
            card_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_HUNT: begin
                  if (!line_bit) begin
                     phase_in = PH_DATA;
                  end else if (hunt_ff <= 16'd1) begin
                     // a zero timeout behaves as one
                     hunt_in   = '0;
                     phase_in  = PH_IDLE;
                     res.valid = 1'b1;
                     res.kind  = KIND_TIMEOUT;
                  end else begin
                     hunt_in = hunt_ff - 16'd1;
                  end
               end
               PH_DATA: begin
                  crc_in = crc_next;
                  cnt_in = cnt_ff + 3'd1;
                  if (cnt_ff == 3'd7) begin
                     res.valid     = 1'b1;
                     res.kind      = KIND_BYTE;
                     res.data_byte = byte_next;
                     shift_in      = '0;
                     if (idx_inc >= BLOCK_BYTES) begin
                        idx_in   = '0;
                        phase_in = PH_CRC;
                     end else begin
                        idx_in = idx_inc;
                     end
                  end else begin
                     shift_in = byte_next;
                  end
               end
               PH_CRC: begin
                  card_in = {card_ff[14:0], line_bit};
                  if (idx_inc >= CRC_BITS) begin
                     idx_in   = '0;
                     phase_in = PH_END;
                  end else begin
                     idx_in = idx_inc;
                  end
               end
               PH_END: begin
                  // end bit level is not checked
                  phase_in         = PH_IDLE;
                  res.valid        = 1'b1;
                  res.received_crc = card_ff;
                  if (crc_ff != card_ff) begin
                     err_in              = err_ff + 32'd1;
                     res.kind            = KIND_CRC_ERR;
                     res.crc_error_total = err_ff + 32'd1;
                  end else begin
                     res.kind = KIND_OK;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hunt_ff  <= '0;
         idx_ff   <= '0;
         shift_ff <= '0;
         cnt_ff   <= '0;
         crc_ff   <= '0;
         card_ff  <= '0;
         err_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hunt_ff  <= hunt_in;
         idx_ff   <= idx_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         card_ff  <= card_in;
         err_ff   <= err_in;
      end
   end

   a_timeout_from_hunt: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_TIMEOUT |-> phase_ff == PH_HUNT)
      else $error("timeout outside start-bit hunt");

   a_byte_from_data: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_BYTE |-> phase_ff == PH_DATA && cnt_ff == 3'd7)
      else $error("data byte emitted before eight bits packed");

   a_err_count_on_mismatch: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && err_ff != $past(err_ff)
      |-> $past(res.valid) && $past(res.kind) == KIND_CRC_ERR)
      else $error("crc error count moved without a crc mismatch");

endmodule

>>> sv/mmc_data_block_receiver_top.sv
// ----------------------------------------------------------------------------
// mmc_data_block_receiver_top
// One-bit MMC DAT0 block receiver with start-bit timeout and CRC16 check.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  req     | in        | req_valid/stall    | command, line_bit
//  rsp     | out       | rsp_valid/stall    | result_kind, data_byte,
//          |           |                    | received_crc, crc_error_total
//  csr     | in        | csr_wr_en          | start_timeout (16 bit)
//
//  One beat per cycle unless a result stalls; the rate is set by the single
//  input register feeding the receive engine, and each result is registered.
//  Synchronous active-high reset; timeout register resets to 10000.
//  A stalled result holds the input register; req_stall rises only then.
// ----------------------------------------------------------------------------
module mmc_data_block_receiver_top
   import mmcrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_line_bit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_received_crc,
   output logic [31:0] rsp_crc_error_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff, in_bit_ff;
   logic [15:0] timeout_ff;
   logic        out_valid_ff, out_valid_in;
   res_type     out_ff;

   logic        out_free;
   logic        proceed;
   logic        req_take;
   res_type     res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign proceed   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   mmcrx_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (proceed),
      .command       (in_cmd_ff),
      .line_bit      (in_bit_ff),
      .start_timeout (timeout_ff),
      .res           (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (proceed && res.valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff <= req_command;
         in_bit_ff <= req_line_bit;
      end
      if (proceed && res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_ff.kind;
   assign rsp_data_byte       = out_ff.data_byte;
   assign rsp_received_crc    = out_ff.received_crc;
   assign rsp_crc_error_total = out_ff.crc_error_total;

   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_cmd_ff) && $stable(in_bit_ff))
      else $error("held input beat lost while result stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !proceed)
      else $error("engine stepped while stalled result pending");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind != KIND_BYTE |-> out_ff.data_byte == 8'd0)
      else $error("status result carries a data byte");

endmodule

>>> bench/mmc_rx_checker.sv
// ----------------------------------------------------------------------------
// mmc_rx_checker
// Watches the req, rsp and csr ports of the MMC block receiver. It keeps its
// own copy of the receive state, predicts the result of every accepted beat
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mmc_rx_checker
   import mmcrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic        req_line_bit,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_result_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [15:0] rsp_received_crc,
   input  logic [31:0] rsp_crc_error_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatches,
   output int          results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] timeout_reg;
   phase_type   rx_phase;
   logic [15:0] hunt_left;
   logic [12:0] count_idx;     // data bytes done, or crc bits taken
   logic [7:0]  shift_byte;
   logic [2:0]  bits_in_byte;
   logic [15:0] crc_calc;
   logic [15:0] crc_card;
   logic [31:0] crc_err_count;

   res_type rx_results_due[$];

   // Advances the receive state by one beat; valid is set when a result is due
   function automatic res_type decode_line_beat(input cmd_type cmd, input logic line_bit);
      res_type r;
      logic    fb;
      r = '0;
      r.crc_error_total = crc_err_count;
      if (cmd == CMD_ARM) begin
         rx_phase     = PH_HUNT;
         hunt_left    = timeout_reg;
         count_idx    = '0;
         shift_byte   = '0;
         bits_in_byte = '0;
         crc_calc     = '0;
         crc_card     = '0;
         return r;
      end
      case (rx_phase)
         PH_HUNT: begin
            if (!line_bit) begin
               rx_phase = PH_DATA;
            end else if (hunt_left <= 16'd1) begin
               // a zero register behaves as one
               hunt_left = '0;
               rx_phase  = PH_IDLE;
               r.valid   = 1'b1;
               r.kind    = KIND_TIMEOUT;
            end else begin
               hunt_left = hunt_left - 16'd1;
            end
         end
         PH_DATA: begin
            fb           = crc_calc[15] ^ line_bit;
            crc_calc     = {crc_calc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            shift_byte   = {shift_byte[6:0], line_bit};
            bits_in_byte = bits_in_byte + 3'd1;
            if (bits_in_byte == 3'd0) begin
               r.valid     = 1'b1;
               r.kind      = KIND_BYTE;
               r.data_byte = shift_byte;
               count_idx   = count_idx + 13'd1;
               if (count_idx >= BLOCK_BYTES) begin
                  count_idx = '0;
                  rx_phase  = PH_CRC;
               end
               shift_byte = '0;
            end
         end
         PH_CRC: begin
            crc_card  = {crc_card[14:0], line_bit};
            count_idx = count_idx + 13'd1;
            if (count_idx >= CRC_BITS) begin
               count_idx = '0;
               rx_phase  = PH_END;
            end
         end
         PH_END: begin
            // end bit level is not checked
            rx_phase       = PH_IDLE;
            r.valid        = 1'b1;
            r.received_crc = crc_card;
            if (crc_calc != crc_card) begin
               crc_err_count = crc_err_count + 32'd1;
               r.kind        = KIND_CRC_ERR;
            end else begin
               r.kind = KIND_OK;
            end
            r.crc_error_total = crc_err_count;
         end
         default: begin
            // idle: samples are dropped
            rx_phase = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         timeout_reg   = TIMEOUT_RESET;
         rx_phase      = PH_IDLE;
         hunt_left     = '0;
         count_idx     = '0;
         shift_byte    = '0;
         bits_in_byte  = '0;
         crc_calc      = '0;
         crc_card      = '0;
         crc_err_count = '0;
         rx_results_due.delete();
         results_due  <= 0;
      end else begin
         // results first: a beat taken at this edge cannot have its result yet
         if (rsp_valid && !rsp_stall) begin
            if (rx_results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result kind=%0d byte=%02h crc=%04h total=%0d",
                        $time, rsp_result_kind, rsp_data_byte, rsp_received_crc,
                        rsp_crc_error_total);
            end else begin
               want = rx_results_due.pop_front();
               if (rsp_result_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_received_crc !== want.received_crc ||
                   rsp_crc_error_total !== want.crc_error_total) begin
                  mismatches++;
                  $display("%0t: mismatch exp kind=%0d byte=%02h crc=%04h total=%0d",
                           $time, want.kind, want.data_byte, want.received_crc,
                           want.crc_error_total);
                  $display("%0t:          got kind=%0d byte=%02h crc=%04h total=%0d",
                           $time, rsp_result_kind, rsp_data_byte, rsp_received_crc,
                           rsp_crc_error_total);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = decode_line_beat(cmd_type'(req_command), req_line_bit);
            if (want.valid) begin
               rx_results_due.push_back(want);
            end
         end
         if (csr_wr_en) begin
            timeout_reg = csr_wr_data;
         end
         results_due <= rx_results_due.size();
      end
   end

endmodule

>>> bench/mmc_data_block_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// mmc_data_block_receiver_top_tb
// Drives the MMC block receiver with arm commands and DAT0 samples: short
// directed sequences, then abandoned receives, part-filled data bytes and
// start-bit timeouts over several timeout settings, under varying idle/stall.
// ----------------------------------------------------------------------------
module mmc_data_block_receiver_top_tb;
   import mmcrx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          DRAIN_HOLD  = 8;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic        req_command  = CMD_SAMPLE;
   logic        req_line_bit = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_received_crc;
   logic [31:0] rsp_crc_error_total;
   logic        csr_wr_en    = 1'b0;
   logic [15:0] csr_wr_data  = '0;

   int          mismatches;
   int          results_due;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   logic [15:0] timeout_now   = TIMEOUT_RESET;
   int unsigned cycle_count   = 0;

   mmc_data_block_receiver_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_line_bit        (req_line_bit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_received_crc    (rsp_received_crc),
      .rsp_crc_error_total (rsp_crc_error_total),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   mmc_rx_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_line_bit        (req_line_bit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_received_crc    (rsp_received_crc),
      .rsp_crc_error_total (rsp_crc_error_total),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mismatches          (mismatches),
      .results_due         (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("mmc_data_block_receiver_top_tb: FAIL");
         $finish;
      end
   end

   task automatic send_beat(input cmd_type cmd, input logic line_bit);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_line_bit <= line_bit;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_byte(input logic [7:0] value);
      for (int i = 7; i >= 0; i--) begin
         send_beat(CMD_SAMPLE, value[i]);
      end
   endtask

   // Stop sending until every due result has come out, then let the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      timeout_now  = value;
   endtask

   // High samples before the start bit, kept short of the timeout
   function automatic int hunt_length();
      if (timeout_now <= 16'd1) begin
         return 0;
      end
      return $urandom_range(0, (timeout_now > 16'd25) ? 24 : int'(timeout_now) - 1);
   endfunction

   task automatic send_noise();
      repeat ($urandom_range(3)) send_beat(CMD_SAMPLE, 1'($urandom_range(1)));
   endtask

   task automatic send_timeout();
      send_beat(CMD_ARM, 1'($urandom_range(1)));
      repeat ((timeout_now == 16'd0) ? 1 : int'(timeout_now)) send_beat(CMD_SAMPLE, 1'b1);
   endtask

   // Arm, then leave the receive part way through the hunt or the data
   task automatic send_abandoned();
      send_beat(CMD_ARM, 1'($urandom_range(1)));
      repeat (hunt_length()) send_beat(CMD_SAMPLE, 1'b1);
      if ($urandom_range(3) != 0) begin
         send_beat(CMD_SAMPLE, 1'b0);
         repeat ($urandom_range(0, 48)) send_beat(CMD_SAMPLE, 1'($urandom_range(1)));
      end
   endtask

   task automatic send_mix(input int count);
      repeat (count) begin
         if ($urandom_range(9) < 5 || timeout_now > 16'd64) begin
            send_abandoned();
         end else begin
            send_timeout();
            send_noise();
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int hold_pct, input logic [15:0] tmo,
                            input int count);
      drain_results();
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      write_timeout(tmo);
      send_noise();
      send_mix(count);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // samples with nothing armed are dropped
      send_beat(CMD_SAMPLE, 1'b1);
      send_beat(CMD_SAMPLE, 1'b0);
      // reset timeout, two high samples, start bit, then all-ones and all-zeros bytes
      send_beat(CMD_ARM, 1'b0);
      send_beat(CMD_SAMPLE, 1'b1);
      send_beat(CMD_SAMPLE, 1'b1);
      send_beat(CMD_SAMPLE, 1'b0);
      send_byte(8'hFF);
      send_byte(8'h00);
      // re-arm in the middle of a block
      send_beat(CMD_ARM, 1'b1);
      drain_results();
      // zero timeout: the first high sample times out
      write_timeout(16'd0);
      send_beat(CMD_ARM, 1'b1);
      send_beat(CMD_SAMPLE, 1'b1);

      run_phase(29, 53, 16'($urandom_range(2, 40)), 8);
      run_phase(53, 29, 16'd1, 8);
      run_phase(0, 0, 16'hFFFF, 6);
      run_phase(0, 0, 16'($urandom_range(41, 64)), 8);

      drain_results();
      if (mismatches == 0 && results_due == 0) begin
         $display("mmc_data_block_receiver_top_tb: PASS");
      end else begin
         $display("mmc_data_block_receiver_top_tb: FAIL");
      end
      $finish;
   end

endmodule
